/* hdl/tpmc_pkg.sv */
// Package: shared types, codes and reset values for the tank pump mode controller.
`timescale 1ns / 1ps

package tpmc_pkg;

    // Field widths
    localparam int KindW   = 2;
    localparam int LevelW  = 8;
    localparam int CountW  = 8;
    localparam int StartW  = 4;
    localparam int ModeW   = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 8;

    // Register reset values
    localparam logic [LevelW-1:0] PumpThresholdRst = 8'd90;
    localparam logic [CountW-1:0] OffHoldTicksRst  = 8'd20;
    localparam logic [CountW-1:0] FlashTicksRst    = 8'd10;
    localparam logic [StartW-1:0] StartupTicksRst  = 4'd6;

    // Counter saturation value
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // Operating modes
    typedef enum logic [ModeW-1:0] {
        MODE_IDLE  = 3'd0,
        MODE_WAIT  = 3'd1,
        MODE_PUMP  = 3'd2,
        MODE_OFF   = 3'd3,
        MODE_FLASH = 3'd4
    } mode_t;

    // Event kinds on the input channel
    typedef enum logic [KindW-1:0] {
        KIND_TICK  = 2'd0,
        KIND_GREEN = 2'd1,
        KIND_RED   = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_PUMP_THRESHOLD = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_OFF_HOLD_TICKS = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_FLASH_TICKS    = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_STARTUP_TICKS  = 2'd3;

    // Lamp and relay drive bits
    typedef struct packed {
        logic blue;
        logic green;
        logic red;
        logic relay;
    } lamps_t;

    // One result transaction
    typedef struct packed {
        lamps_t lamps;
        mode_t  mode;
    } result_t;

endpackage

/* hdl/tpmc_if.sv */
// Interfaces: event input, result output and configuration write channels.
`timescale 1ns / 1ps

interface tpmc_event_if;
    logic                         valid;
    logic                         ready;
    logic [tpmc_pkg::KindW-1:0]   kind;
    logic [tpmc_pkg::LevelW-1:0]  water_level;

    modport source (output valid, kind, water_level, input ready);
    modport sink   (input valid, kind, water_level, output ready);
endinterface

interface tpmc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         relay_on;
    logic                         red_lamp;
    logic                         green_lamp;
    logic                         blue_lamp;
    logic [tpmc_pkg::ModeW-1:0]   current_mode;

    modport source (output valid, relay_on, red_lamp, green_lamp, blue_lamp, current_mode,
                    input ready);
    modport sink   (input valid, relay_on, red_lamp, green_lamp, blue_lamp, current_mode,
                    output ready);
endinterface

interface tpmc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tpmc_pkg::CfgIdxW-1:0]  index;
    logic [tpmc_pkg::CfgDatW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/tank_pump_mode_controller.sv */
// Top level: five-mode pump controller with a two-entry result buffer.
//
//  Channel   Dir  Payload                                          Transaction
//  in_ch     in   kind, water_level                                valid & ready
//  out_ch    out  relay_on, red_lamp, green_lamp, blue_lamp, mode  valid & ready
//  cfg_ch    in   index, data                                      valid & ready
//
//  The mode step is computed from the state registers and the event; the result is
//  registered on acceptance, in the output register if it is empty or being read,
//  else in the skid register. One event per cycle is accepted while skid is empty.
//  An output register plus a skid register hold up to two results, so in_ch stalls
//  only when both are full. cfg_ch is always ready.
//  Reset (rst_n low, asynchronous) restores idle mode, clears counters and lamps
//  and loads the register defaults.
`timescale 1ns / 1ps

module tank_pump_mode_controller (
    input  logic           clk,
    input  logic           rst_n,
    tpmc_event_if.sink     in_ch,
    tpmc_result_if.source  out_ch,
    tpmc_cfg_if.sink       cfg_ch
);

    // Configuration registers
    logic [tpmc_pkg::LevelW-1:0] pump_threshold_reg;
    logic [tpmc_pkg::CountW-1:0] off_hold_ticks_reg;
    logic [tpmc_pkg::CountW-1:0] flash_ticks_reg;
    logic [tpmc_pkg::StartW-1:0] startup_ticks_reg;

    // Controller state
    tpmc_pkg::mode_t             mode_reg, mode_next;
    logic [tpmc_pkg::CountW-1:0] hold_count_reg, hold_count_next;
    logic [tpmc_pkg::CountW-1:0] flash_count_reg, flash_count_next;
    logic [tpmc_pkg::StartW-1:0] startup_count_reg, startup_count_next;
    tpmc_pkg::lamps_t            lamps_reg, lamps_next;

    // Result buffer
    tpmc_pkg::result_t out_reg, out_next;
    tpmc_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    logic              push;
    logic              pop;
    logic              cfg_write;
    logic              started;
    logic              started_now;
    logic [tpmc_pkg::CountW-1:0] hold_inc;
    logic [tpmc_pkg::CountW-1:0] flash_inc;
    tpmc_pkg::result_t new_result;

    // Handshakes
    assign in_ch.ready  = !skid_valid_reg;
    assign cfg_ch.ready = 1'b1;
    assign push         = in_ch.valid && in_ch.ready;
    assign pop          = out_valid_reg && out_ch.ready;
    assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

    assign started   = startup_count_reg >= startup_ticks_reg;
    assign hold_inc  = (hold_count_reg == tpmc_pkg::CountMax) ? hold_count_reg
                                                              : hold_count_reg + 8'd1;
    assign flash_inc = (flash_count_reg == tpmc_pkg::CountMax) ? flash_count_reg
                                                               : flash_count_reg + 8'd1;

    // Event handling and mode step
    always_comb
    begin
        mode_next          = mode_reg;
        hold_count_next    = hold_count_reg;
        flash_count_next   = flash_count_reg;
        startup_count_next = startup_count_reg;
        lamps_next         = lamps_reg;
        started_now        = started;

        case (tpmc_pkg::kind_t'(in_ch.kind))
            tpmc_pkg::KIND_TICK:
            begin
                // start-up blink
                if (!started)
                begin
                    startup_count_next = startup_count_reg + 4'd1;
                    lamps_next.blue    = !lamps_reg.blue;
                    started_now        = startup_count_next >= startup_ticks_reg;
                end
                if (started_now)
                begin
                    case (mode_reg)
                        tpmc_pkg::MODE_IDLE:
                        begin
                            lamps_next.blue = !lamps_next.blue;
                        end
                        tpmc_pkg::MODE_WAIT:
                        begin
                            lamps_next.relay = 1'b0;
                            lamps_next.red   = 1'b0;
                            lamps_next.blue  = 1'b0;
                            if (in_ch.water_level > pump_threshold_reg)
                                mode_next = tpmc_pkg::MODE_PUMP;
                            else
                                lamps_next.green = !lamps_next.green;
                        end
                        tpmc_pkg::MODE_PUMP:
                        begin
                            lamps_next.relay = 1'b1;
                            lamps_next.green = 1'b1;
                            lamps_next.red   = 1'b0;
                            lamps_next.blue  = 1'b0;
                            if (in_ch.water_level < pump_threshold_reg)
                                mode_next = tpmc_pkg::MODE_WAIT;
                        end
                        tpmc_pkg::MODE_OFF:
                        begin
                            lamps_next.red   = 1'b1;
                            lamps_next.green = 1'b0;
                            lamps_next.blue  = 1'b0;
                            lamps_next.relay = 1'b0;
                            hold_count_next  = hold_inc;
                            if (hold_inc >= off_hold_ticks_reg)
                            begin
                                mode_next        = tpmc_pkg::MODE_FLASH;
                                hold_count_next  = '0;
                                lamps_next.green = 1'b1;
                            end
                        end
                        tpmc_pkg::MODE_FLASH:
                        begin
                            lamps_next.red   = !lamps_next.red;
                            lamps_next.green = !lamps_next.green;
                            flash_count_next = flash_inc;
                            if (flash_inc > flash_ticks_reg)
                            begin
                                mode_next        = tpmc_pkg::MODE_IDLE;
                                flash_count_next = '0;
                                lamps_next.red   = 1'b0;
                                lamps_next.green = 1'b0;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            tpmc_pkg::KIND_GREEN:
            begin
                if (started)
                    mode_next = tpmc_pkg::MODE_WAIT;
            end
            tpmc_pkg::KIND_RED:
            begin
                if (started)
                    mode_next = tpmc_pkg::MODE_OFF;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        new_result.lamps = lamps_next;
        new_result.mode  = mode_next;
    end

    // Result buffer: output register with a skid register behind it
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = new_result;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = new_result;
            skid_valid_next = 1'b1;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= tpmc_pkg::MODE_IDLE;
            hold_count_reg     <= '0;
            flash_count_reg    <= '0;
            startup_count_reg  <= '0;
            lamps_reg          <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
            pump_threshold_reg <= tpmc_pkg::PumpThresholdRst;
            off_hold_ticks_reg <= tpmc_pkg::OffHoldTicksRst;
            flash_ticks_reg    <= tpmc_pkg::FlashTicksRst;
            startup_ticks_reg  <= tpmc_pkg::StartupTicksRst;
        end
        else
        begin
            if (push)
            begin
                mode_reg          <= mode_next;
                hold_count_reg    <= hold_count_next;
                flash_count_reg   <= flash_count_next;
                startup_count_reg <= startup_count_next;
                lamps_reg         <= lamps_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_write)
            begin
                case (cfg_ch.index)
                    tpmc_pkg::REG_PUMP_THRESHOLD: pump_threshold_reg <= cfg_ch.data;
                    tpmc_pkg::REG_OFF_HOLD_TICKS: off_hold_ticks_reg <= cfg_ch.data;
                    tpmc_pkg::REG_FLASH_TICKS:    flash_ticks_reg    <= cfg_ch.data;
                    tpmc_pkg::REG_STARTUP_TICKS:
                        startup_ticks_reg <= cfg_ch.data[tpmc_pkg::StartW-1:0];
                    default: pump_threshold_reg <= pump_threshold_reg;
                endcase
            end
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Output drive
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.relay_on     = out_reg.lamps.relay;
    assign out_ch.red_lamp     = out_reg.lamps.red;
    assign out_ch.green_lamp   = out_reg.lamps.green;
    assign out_ch.blue_lamp    = out_reg.lamps.blue;
    assign out_ch.current_mode = out_reg.mode;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while output register is empty");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_valid_reg) |=> (out_valid_reg && out_reg.mode == $past(mode_next)))
        else $error("accepted event did not reach the output register");

    a_flash_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == tpmc_pkg::MODE_FLASH && $past(mode_reg) == tpmc_pkg::MODE_OFF)
            |-> (lamps_reg.red && lamps_reg.green && !lamps_reg.relay))
        else $error("flash mode entered without red and green lit");

endmodule
